FILE: sv/uhv_pkg.sv
// Shared types and constants for the update header validator.
// Depends on nothing; imported by every module of the block.
package uhv_pkg;

    localparam logic [6:0]  HDR_BYTES   = 7'd64;
    localparam logic [6:0]  CRC_SPAN    = 7'd60;
    localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
    localparam logic [31:0] ALGO_V1     = 32'd1;
    localparam logic [31:0] KEY_V1      = 32'd1;
    localparam logic [31:0] PATCH_INNER = 32'd40;

    // magic bytes, byte 0 at index 0
    localparam logic [3:0][7:0] MAGIC_BYTES = {8'h31, 8'h55, 8'h54, 8'h45};

    // verdict codes
    localparam logic [3:0] STAT_OK      = 4'd0;
    localparam logic [3:0] STAT_MAGIC   = 4'd1;
    localparam logic [3:0] STAT_HDR_LEN = 4'd2;
    localparam logic [3:0] STAT_HDR_CRC = 4'd3;
    localparam logic [3:0] STAT_FLAGS   = 4'd4;
    localparam logic [3:0] STAT_ALGO    = 4'd5;
    localparam logic [3:0] STAT_KEY     = 4'd6;
    localparam logic [3:0] STAT_HW      = 4'd7;
    localparam logic [3:0] STAT_LAYOUT  = 4'd8;
    localparam logic [3:0] STAT_BOOT    = 4'd9;
    localparam logic [3:0] STAT_VERSION = 4'd10;
    localparam logic [3:0] STAT_BASE    = 4'd11;
    localparam logic [3:0] STAT_LENGTH  = 4'd12;

    typedef struct packed {
        logic [7:0] header_byte;
        logic       header_start;
    } hdr_item_t;

    typedef struct packed {
        logic [3:0]  status;
        logic        is_patch;
        logic [31:0] payload_length;
        logic [31:0] payload_checksum;
        logic [31:0] target_version;
        logic [31:0] base_version;
    } res_item_t;

    typedef struct packed {
        logic [15:0] hardware_revision;
        logic [7:0]  layout_code;
        logic [7:0]  loader_version;
        logic [31:0] current_version;
        logic [63:0] base_image_digest;
        logic [15:0] full_flags_value;
        logic [15:0] patch_flags_value;
        logic [31:0] image_total_len;
    } cfg_t;

    // captured header state
    typedef struct packed {
        logic [31:0]      crc;
        logic             magic_ok;
        logic [15:0]      hdr_len;
        logic [15:0]      flags;
        logic [31:0]      algo;
        logic [31:0]      key;
        logic [3:0][31:0] pay;     // length, checksum, target, base
        logic [31:0]      board;
        logic [63:0]      digest;
        logic [31:0]      stored_crc;
    } hdr_state_t;

    localparam hdr_state_t HDR_CLEAR = '{
        crc: 32'hFFFF_FFFF, magic_ok: 1'b1, hdr_len: 16'd0, flags: 16'd0,
        algo: 32'd0, key: 32'd0, pay: '0, board: 32'd0, digest: 64'd0,
        stored_crc: 32'd0};

    // one byte of reflected CRC-32, bit at a time
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

FILE: sv/update_header_validator_core.sv
// Top level of the update header validator: configuration registers and stage wiring.
// Depends on uhv_pkg, uhv_capture and uhv_verdict.

// A 64-byte update-package header enters one byte per item on the hdr channel,
// with header_start marking byte 0 (it also aborts any partial header). The
// capture stage takes one byte every cycle, folding bytes 0..59 into a
// reflected CRC-32 and latching the little-endian fields. Once it has
// byte 63, the verdict stage runs the ordered checks (magic, header length,
// header CRC, flags, algorithm, key, hardware revision, layout, boot
// version, target version, base rules, lengths) and loads one result item.
// Throughput is one byte per clock but for a stall, so a header costs 64 accepted items
// and its verdict passes the done register, then the result register; the only stall is a
// completed header whose result register is still occupied by an untaken
// result. Bytes after byte 63 without a new start are swallowed silently.
// Registers sit on a 64-bit APB-style port at byte address 8*index; write
// them only while no header is in flight.
module update_header_validator_core import uhv_pkg::*;
#(
    parameter logic [31:0] MAX_PACKAGE_BYTES = 32'd1048576
)
(
    input  logic        clk,
    input  logic        rst_n,
    // header bytes
    input  logic        hdr_valid,
    output logic        hdr_ready,
    input  hdr_item_t   hdr_item,
    // verdicts
    output logic        res_valid,
    input  logic        res_ready,
    output res_item_t   res_item,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    typedef enum logic [2:0] {
        REG_HW_REV     = 3'd0,
        REG_LAYOUT     = 3'd1,
        REG_BOOT       = 3'd2,
        REG_CUR_VER    = 3'd3,
        REG_BASE_DIG   = 3'd4,
        REG_FULL_FLAGS = 3'd5,
        REG_PATCH_FLAGS= 3'd6,
        REG_PKG_LEN    = 3'd7
    } reg_idx_t;

    cfg_t       cfg_reg, cfg_next;
    reg_idx_t   reg_idx;
    logic       wr_en;
    logic       hdr_taken;
    logic       hdr_done;
    hdr_state_t hdr_state;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[5:3]);
    assign wr_en   = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_HW_REV:      cfg_next.hardware_revision = pwdata[15:0];
                REG_LAYOUT:      cfg_next.layout_code       = pwdata[7:0];
                REG_BOOT:        cfg_next.loader_version    = pwdata[7:0];
                REG_CUR_VER:     cfg_next.current_version   = pwdata[31:0];
                REG_BASE_DIG:    cfg_next.base_image_digest = pwdata;
                REG_FULL_FLAGS:  cfg_next.full_flags_value  = pwdata[15:0];
                REG_PATCH_FLAGS: cfg_next.patch_flags_value = pwdata[15:0];
                REG_PKG_LEN:     cfg_next.image_total_len   = pwdata[31:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_HW_REV:      prdata = {48'd0, cfg_reg.hardware_revision};
            REG_LAYOUT:      prdata = {56'd0, cfg_reg.layout_code};
            REG_BOOT:        prdata = {56'd0, cfg_reg.loader_version};
            REG_CUR_VER:     prdata = {32'd0, cfg_reg.current_version};
            REG_BASE_DIG:    prdata = cfg_reg.base_image_digest;
            REG_FULL_FLAGS:  prdata = {48'd0, cfg_reg.full_flags_value};
            REG_PATCH_FLAGS: prdata = {48'd0, cfg_reg.patch_flags_value};
            REG_PKG_LEN:     prdata = {32'd0, cfg_reg.image_total_len};
            default:         prdata = 64'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    uhv_capture u_capture
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .hdr_valid (hdr_valid),
        .hdr_ready (hdr_ready),
        .hdr_item  (hdr_item),
        .hdr_taken (hdr_taken),
        .hdr_done  (hdr_done),
        .hdr_state (hdr_state)
    );

    uhv_verdict #(
        .MAX_PACKAGE_BYTES (MAX_PACKAGE_BYTES)
    ) u_verdict
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .hdr_done  (hdr_done),
        .hdr_state (hdr_state),
        .cfg       (cfg_reg),
        .hdr_taken (hdr_taken),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item)
    );

endmodule

FILE: sv/uhv_capture.sv
// Byte capture stage: byte counter, running CRC and field registers.
// Depends on uhv_pkg.
module uhv_capture import uhv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       hdr_valid,
    output logic       hdr_ready,
    input  hdr_item_t  hdr_item,
    input  logic       hdr_taken,
    output logic       hdr_done,
    output hdr_state_t hdr_state
);

    logic [6:0] count_reg, count_next;
    hdr_state_t st_reg, st_next;
    logic       done_reg, done_next;

    logic       accept;
    logic [6:0] pos;
    logic       active;
    logic [7:0] b;
    logic [2:0] dig_lane;
    hdr_state_t st_base, st_upd;

    assign hdr_ready = !done_reg || hdr_taken;
    assign accept    = hdr_valid && hdr_ready;
    assign b         = hdr_item.header_byte;
    assign pos       = hdr_item.header_start ? 7'd0 : count_reg;
    assign active    = !pos[6];
    assign dig_lane  = pos[2:0] + 3'd4;   // offset from byte 52

    always_comb
    begin
        st_base = hdr_item.header_start ? HDR_CLEAR : st_reg;
        st_upd  = st_base;
        if (pos < CRC_SPAN)
        begin
            st_upd.crc = crc32_byte(st_base.crc, b);
        end
        case (pos[5:0]) inside
            [6'd0:6'd3]:
            begin
                if (b != MAGIC_BYTES[pos[1:0]])
                begin
                    st_upd.magic_ok = 1'b0;
                end
            end
            [6'd4:6'd5]:   st_upd.hdr_len[{pos[0], 3'b000} +: 8] = b;
            [6'd6:6'd7]:   st_upd.flags[{pos[0], 3'b000} +: 8] = b;
            [6'd8:6'd11]:  st_upd.algo[{pos[1:0], 3'b000} +: 8] = b;
            [6'd12:6'd15]: st_upd.key[{pos[1:0], 3'b000} +: 8] = b;
            [6'd32:6'd47]: st_upd.pay[pos[3:2]][{pos[1:0], 3'b000} +: 8] = b;
            [6'd48:6'd51]: st_upd.board[{pos[1:0], 3'b000} +: 8] = b;
            [6'd52:6'd59]: st_upd.digest[{dig_lane, 3'b000} +: 8] = b;
            [6'd60:6'd63]: st_upd.stored_crc[{pos[1:0], 3'b000} +: 8] = b;
            default:       st_upd = st_upd;   // reserved bytes feed the CRC only
        endcase
    end

    always_comb
    begin
        st_next    = st_reg;
        count_next = count_reg;
        done_next  = done_reg && !hdr_taken;
        if (accept && active)
        begin
            st_next    = st_upd;
            count_next = pos + 7'd1;
            if (pos == HDR_BYTES - 7'd1)
            begin
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= HDR_BYTES;
            st_reg    <= HDR_CLEAR;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            st_reg    <= st_next;
            done_reg  <= done_next;
        end
    end

    assign hdr_done  = done_reg;
    assign hdr_state = st_reg;

endmodule

FILE: sv/uhv_verdict.sv
// Verdict stage: ordered header checks and the result register.
// Depends on uhv_pkg.
module uhv_verdict import uhv_pkg::*;
#(
    parameter logic [31:0] MAX_PACKAGE_BYTES = 32'd1048576
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       hdr_done,
    input  hdr_state_t hdr_state,
    input  cfg_t       cfg,
    output logic       hdr_taken,
    output logic       res_valid,
    input  logic       res_ready,
    output res_item_t  res_item
);

    localparam logic [31:0] PLEN_LIMIT = MAX_PACKAGE_BYTES - 32'd64;

    logic      valid_reg, valid_next;
    res_item_t item_reg, item_next;

    logic [31:0] plen, target, base;
    logic        full;
    logic        len_bad;
    logic [3:0]  status;

    assign plen   = hdr_state.pay[0];
    assign target = hdr_state.pay[2];
    assign base   = hdr_state.pay[3];
    assign full   = hdr_state.flags == cfg.full_flags_value;
    assign len_bad = (plen > PLEN_LIMIT)
                  || ({1'b0, cfg.image_total_len} != ({1'b0, plen} + 33'd64));

    always_comb
    begin
        if (!hdr_state.magic_ok)
            status = STAT_MAGIC;
        else if (hdr_state.hdr_len != {9'd0, HDR_BYTES})
            status = STAT_HDR_LEN;
        else if ((hdr_state.crc ^ 32'hFFFF_FFFF) != hdr_state.stored_crc)
            status = STAT_HDR_CRC;
        else if (!full && hdr_state.flags != cfg.patch_flags_value)
            status = STAT_FLAGS;
        else if (hdr_state.algo != ALGO_V1)
            status = STAT_ALGO;
        else if (hdr_state.key != KEY_V1)
            status = STAT_KEY;
        else if (hdr_state.board[15:0] != cfg.hardware_revision)
            status = STAT_HW;
        else if (hdr_state.board[23:16] != cfg.layout_code)
            status = STAT_LAYOUT;
        else if (hdr_state.board[31:24] > cfg.loader_version)
            status = STAT_BOOT;
        else if (target <= cfg.current_version)
            status = STAT_VERSION;
        else if (full && (base != 32'd0 || hdr_state.digest != 64'd0))
            status = STAT_BASE;
        else if (!full && (base != cfg.current_version
                           || hdr_state.digest != cfg.base_image_digest))
            status = STAT_BASE;
        else if (full && plen == 32'd0)
            status = STAT_LENGTH;
        else if (!full && plen <= PATCH_INNER)
            status = STAT_LENGTH;
        else if (len_bad)
            status = STAT_LENGTH;
        else
            status = STAT_OK;
    end

    assign hdr_taken = hdr_done && (!valid_reg || res_ready);

    always_comb
    begin
        item_next  = item_reg;
        valid_next = valid_reg && !res_ready;
        if (hdr_taken)
        begin
            valid_next                 = 1'b1;
            item_next.status           = status;
            item_next.is_patch         = (status == STAT_OK || status > STAT_FLAGS) && !full;
            item_next.payload_length   = hdr_state.pay[0];
            item_next.payload_checksum = hdr_state.pay[1];
            item_next.target_version   = hdr_state.pay[2];
            item_next.base_version     = hdr_state.pay[3];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign res_valid = valid_reg;
    assign res_item  = item_reg;

endmodule

FILE: tb/update_header_validator_core_tb.sv
// Self-checking bench for update_header_validator_core: header byte stream in, verdicts out.
// Depends on uhv_pkg for the item types, the config struct and the verdict codes.
// Predicts each verdict from the accepted bytes and compares it with what the block returns.
module update_header_validator_core_tb import uhv_pkg::*;
    ;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CLK_PERIOD   = 10;
    localparam int          LIMIT_CYCLES = 200000;
    localparam int          HOLD_CYCLES  = 400;    // long receiver hold-off
    localparam int          DRAIN_LIMIT  = 5000;
    localparam int          SETTLE       = 8;      // wait after the drain so trailing idle bytes pass
    localparam int          UNITS        = 1;      // random stimulus units per phase
    localparam int          PHASES       = 5;

    // independent copies of the header format constants
    localparam logic [31:0] CRC32_POLY      = 32'hEDB8_8320;
    localparam logic [31:0] MAGIC_LE        = 32'h3155_5445;
    localparam logic [31:0] MAX_PKG         = 32'd1048576;
    localparam logic [31:0] HDR_SIZE        = 32'd64;
    localparam logic [31:0] PATCH_INNER_LEN = 32'd40;
    localparam logic [31:0] ALGO_ONE        = 32'd1;
    localparam logic [31:0] KEY_ONE         = 32'd1;

    // register indexes, byte address is 8 * index
    localparam int REG_HW_REV     = 0;
    localparam int REG_LAYOUT     = 1;
    localparam int REG_BOOT       = 2;
    localparam int REG_CUR_VER    = 3;
    localparam int REG_DIGEST     = 4;
    localparam int REG_FULL_FLAGS = 5;
    localparam int REG_PATCH_FLAGS = 6;
    localparam int REG_PKG_LEN    = 7;

    logic        clk     = 1'b0;
    logic        rst_n   = 1'b0;
    logic        hdr_valid = 1'b0;
    logic        hdr_ready;
    hdr_item_t   hdr_item  = '0;
    logic        res_valid;
    logic        res_ready = 1'b0;
    res_item_t   res_item;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [5:0]  paddr   = '0;
    logic [63:0] pwdata  = '0;
    logic [63:0] prdata;
    logic        pready;

    update_header_validator_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .hdr_valid (hdr_valid),
        .hdr_ready (hdr_ready),
        .hdr_item  (hdr_item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    hdr_item_t byte_q[$];       // header bytes waiting to be offered
    res_item_t verdict_q[$];    // predicted verdicts, oldest first
    int        mismatch_count = 0;
    int        tx_pct = 0;      // sender idle chance, percent
    int        rx_pct = 0;      // receiver stall chance, percent
    bit        hold_req = 1'b0;
    logic      rx_blocked = 1'b0;

    // shadow of the configuration registers
    cfg_t cfg_shadow = '0;

    // predictor state: byte position (64 = waiting for a start) and captured fields
    int          hdr_pos = 64;
    logic [31:0] crc_acc;
    logic        magic_good;
    logic [15:0] cap_hlen;
    logic [15:0] cap_flags;
    logic [31:0] cap_algo;
    logic [31:0] cap_key;
    logic [31:0] cap_pay [4];   // length, checksum, target, base
    logic [31:0] cap_board;
    logic [63:0] cap_digest;
    logic [31:0] cap_crc;

    function automatic bit coin(input int pct);
        return $urandom_range(99) < pct;
    endfunction

    // reflected CRC-32, one byte
    function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        repeat (8)
            r = (r >> 1) ^ (CRC32_POLY & {32{r[0]}});
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        $display("%0t ns mismatch: %s got %0h want %0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // ordered header checks; the first one that fails decides
    function automatic logic [3:0] judge_header();
        logic [31:0] plen;
        plen = cap_pay[0];
        if (!magic_good)                                   return STAT_MAGIC;
        if (cap_hlen != HDR_SIZE[15:0])                    return STAT_HDR_LEN;
        if (~crc_acc != cap_crc)                           return STAT_HDR_CRC;
        if (cap_flags != cfg_shadow.full_flags_value &&
            cap_flags != cfg_shadow.patch_flags_value)     return STAT_FLAGS;
        if (cap_algo != ALGO_ONE)                          return STAT_ALGO;
        if (cap_key != KEY_ONE)                            return STAT_KEY;
        if (cap_board[15:0] != cfg_shadow.hardware_revision) return STAT_HW;
        if (cap_board[23:16] != cfg_shadow.layout_code)    return STAT_LAYOUT;
        if (cap_board[31:24] > cfg_shadow.loader_version)  return STAT_BOOT;
        if (cap_pay[2] <= cfg_shadow.current_version)      return STAT_VERSION;
        // equal flag registers: the full rules win
        if (cap_flags == cfg_shadow.full_flags_value)
        begin
            if (cap_pay[3] != 32'd0 || cap_digest != 64'd0) return STAT_BASE;
            if (plen == 32'd0)                              return STAT_LENGTH;
        end
        else
        begin
            if (cap_pay[3] != cfg_shadow.current_version ||
                cap_digest != cfg_shadow.base_image_digest) return STAT_BASE;
            if (plen <= PATCH_INNER_LEN)                    return STAT_LENGTH;
        end
        if (plen > MAX_PKG - HDR_SIZE ||
            {1'b0, cfg_shadow.image_total_len} != {1'b0, plen} + {1'b0, HDR_SIZE})
            return STAT_LENGTH;
        return STAT_OK;
    endfunction

    // fold one accepted byte into the predictor; byte 63 queues a verdict
    function automatic void absorb_byte(input hdr_item_t it);
        logic [7:0] b;
        int         p;
        res_item_t  r;
        b = it.header_byte;
        if (it.header_start)
        begin
            // a start always discards whatever partial header was there
            hdr_pos    = 0;
            crc_acc    = '1;
            magic_good = 1'b1;
            cap_hlen   = '0;
            cap_flags  = '0;
            cap_algo   = '0;
            cap_key    = '0;
            for (int i = 0; i < 4; i++)
                cap_pay[i] = '0;
            cap_board  = '0;
            cap_digest = '0;
            cap_crc    = '0;
        end
        if (hdr_pos < 64)
        begin
            p = hdr_pos;
            if (p < 60)
                crc_acc = crc_step(crc_acc, b);
            if (p < 4)
            begin
                if (b != MAGIC_LE[p*8 +: 8])
                    magic_good = 1'b0;
            end
            else if (p < 6)  cap_hlen[(p-4)*8 +: 8]  = b;
            else if (p < 8)  cap_flags[(p-6)*8 +: 8] = b;
            else if (p < 12) cap_algo[(p-8)*8 +: 8]  = b;
            else if (p < 16) cap_key[(p-12)*8 +: 8]  = b;
            else if (p < 32) ;  // reserved, CRC only
            else if (p < 48) cap_pay[(p-32)/4][((p-32)%4)*8 +: 8] = b;
            else if (p < 52) cap_board[(p-48)*8 +: 8]  = b;
            else if (p < 60) cap_digest[(p-52)*8 +: 8] = b;
            else             cap_crc[(p-60)*8 +: 8]    = b;
            hdr_pos++;
            if (hdr_pos == 64)
            begin
                r.status           = judge_header();
                r.is_patch         = (r.status == STAT_OK || r.status > STAT_FLAGS) &&
                                     cap_flags != cfg_shadow.full_flags_value;
                r.payload_length   = cap_pay[0];
                r.payload_checksum = cap_pay[1];
                r.target_version   = cap_pay[2];
                r.base_version     = cap_pay[3];
                verdict_q.push_back(r);
            end
        end
    endfunction

    // sender: offers queued bytes, holds each until taken
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hdr_valid && hdr_ready)
                absorb_byte(hdr_item);
            if (!hdr_valid || hdr_ready)
            begin
                if (byte_q.size() != 0 && !coin(tx_pct))
                begin
                    hdr_item  <= byte_q.pop_front();
                    hdr_valid <= 1'b1;
                end
                else
                    hdr_valid <= 1'b0;
            end
        end
    end

    task automatic compare_field(input string name, input logic [63:0] got,
                                 input logic [63:0] want);
        if (got !== want)
            flag_mismatch(name, got, want);
    endtask

    task automatic check_verdict(input res_item_t got);
        res_item_t want;
        if (verdict_q.size() == 0)
        begin
            flag_mismatch("verdict with nothing pending, status", got.status, 0);
            return;
        end
        want = verdict_q.pop_front();
        compare_field("status", got.status, want.status);
        compare_field("is_patch", got.is_patch, want.is_patch);
        compare_field("payload_length", got.payload_length, want.payload_length);
        compare_field("payload_checksum", got.payload_checksum, want.payload_checksum);
        compare_field("target_version", got.target_version, want.target_version);
        compare_field("base_version", got.base_version, want.base_version);
    endtask

    // receiver: takes verdicts, stalls at random or during the forced hold-off
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_valid && res_ready)
                check_verdict(res_item);
            res_ready <= !rx_blocked && !coin(rx_pct);
        end
    end

    // long hold-off, counted here so the sender keeps offering meanwhile
    initial
    begin
        wait (hold_req);
        @(posedge clk);
        rx_blocked <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_blocked <= 1'b0;
    end

    // APB write: setup cycle, access cycle, register taken with pready
    task automatic write_reg(input int idx, input logic [63:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 6'(idx * 8);
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_HW_REV:      cfg_shadow.hardware_revision = val[15:0];
            REG_LAYOUT:      cfg_shadow.layout_code       = val[7:0];
            REG_BOOT:        cfg_shadow.loader_version    = val[7:0];
            REG_CUR_VER:     cfg_shadow.current_version   = val[31:0];
            REG_DIGEST:      cfg_shadow.base_image_digest = val;
            REG_FULL_FLAGS:  cfg_shadow.full_flags_value  = val[15:0];
            REG_PATCH_FLAGS: cfg_shadow.patch_flags_value = val[15:0];
            REG_PKG_LEN:     cfg_shadow.image_total_len   = val[31:0];
            default: ;
        endcase
    endtask

    task automatic load_config(input cfg_t c);
        // upper bits carry junk to show the block keeps only the register width
        write_reg(REG_HW_REV,      {$urandom, 16'($urandom), c.hardware_revision});
        write_reg(REG_LAYOUT,      {$urandom, 24'($urandom), c.layout_code});
        write_reg(REG_BOOT,        {$urandom, 24'($urandom), c.loader_version});
        write_reg(REG_CUR_VER,     {$urandom, c.current_version});
        write_reg(REG_DIGEST,      c.base_image_digest);
        write_reg(REG_FULL_FLAGS,  {$urandom, 16'($urandom), c.full_flags_value});
        write_reg(REG_PATCH_FLAGS, {$urandom, 16'($urandom), c.patch_flags_value});
        write_reg(REG_PKG_LEN,     {$urandom, c.image_total_len});
    endtask

    function automatic cfg_t random_config();
        cfg_t c;
        c.hardware_revision = 16'($urandom);
        c.layout_code       = 8'($urandom);
        c.loader_version    = 8'($urandom_range(254, 1));
        c.current_version   = $urandom_range(32'hFFFF_0000, 0);
        c.base_image_digest = {$urandom, $urandom};
        c.full_flags_value  = 16'($urandom);
        c.patch_flags_value = c.full_flags_value ^ (16'd1 << $urandom_range(15));
        c.image_total_len   = HDR_SIZE + ($urandom_range(1) ? $urandom_range(300, 41)
                                          : $urandom_range(MAX_PKG - HDR_SIZE, 41));
        return c;
    endfunction

    function automatic void push_byte(input logic [7:0] b, input logic s);
        hdr_item_t it;
        it.header_byte  = b;
        it.header_start = s;
        byte_q.push_back(it);
    endfunction

    // bytes with no start: ignored once a header is complete
    function automatic void queue_idle(input int n);
        for (int i = 0; i < n; i++)
            push_byte(8'($urandom), 1'b0);
    endfunction

    function automatic logic [31:0] not_one();
        logic [31:0] v;
        case ($urandom_range(2))
            0:       v = 32'd0;
            1:       v = 32'd2;
            default: v = $urandom;
        endcase
        if (v == 32'd1)
            v = 32'hFFFF_FFFF;
        return v;
    endfunction

    // Builds a header that passes under the current settings, then breaks the
    // one check named by fault. keep < 64 cuts it short (next start aborts it).
    task automatic queue_header(input logic [3:0] fault, input int keep);
        logic [7:0]  hb [64];
        logic [31:0] magic, algo, key, plen, tgt, base, crc, cur;
        logic [15:0] hlen, flg, hw;
        logic [7:0]  lay, minb;
        logic [63:0] dig;
        bit          patch;
        for (int i = 0; i < 64; i++)
            hb[i] = 8'($urandom);   // reserved bytes and checksum stay random
        cur   = cfg_shadow.current_version;
        magic = MAGIC_LE;
        hlen  = HDR_SIZE[15:0];
        algo  = ALGO_ONE;
        key   = KEY_ONE;
        flg   = $urandom_range(1) ? cfg_shadow.patch_flags_value : cfg_shadow.full_flags_value;
        patch = (flg != cfg_shadow.full_flags_value);
        hw    = cfg_shadow.hardware_revision;
        lay   = cfg_shadow.layout_code;
        minb  = 8'($urandom_range(cfg_shadow.loader_version, 0));
        if (cur == '1)
            tgt = $urandom;
        else
            tgt = $urandom_range(1) ? cur + 1 : cur + 1 + $urandom_range(~cur - 1, 0);
        base  = patch ? cur : 32'd0;
        dig   = patch ? cfg_shadow.base_image_digest : 64'd0;
        plen  = cfg_shadow.image_total_len - HDR_SIZE;
        case (fault)
            STAT_MAGIC:   magic ^= 32'd1 << $urandom_range(31);
            STAT_HDR_LEN:
            begin
                hlen = $urandom_range(1) ? HDR_SIZE[15:0] ^ (16'd1 << $urandom_range(15))
                                         : 16'($urandom);
                if (hlen == HDR_SIZE[15:0])
                    hlen = 16'd0;
            end
            STAT_FLAGS:
            begin
                flg = 16'($urandom);
                while (flg == cfg_shadow.full_flags_value || flg == cfg_shadow.patch_flags_value)
                    flg++;
            end
            STAT_ALGO:    algo = not_one();
            STAT_KEY:     key = not_one();
            STAT_HW:      hw ^= 16'd1 << $urandom_range(15);
            STAT_LAYOUT:  lay ^= 8'd1 << $urandom_range(7);
            STAT_BOOT:
            begin
                if (cfg_shadow.loader_version != 8'hFF)
                    minb = 8'($urandom_range(255, cfg_shadow.loader_version + 1));
            end
            STAT_VERSION: tgt = $urandom_range(1) ? cur : $urandom_range(cur, 0);
            STAT_BASE:
            begin
                if ($urandom_range(1))
                    base ^= 32'd1 << $urandom_range(31);
                else
                    dig ^= 64'd1 << $urandom_range(63);
            end
            STAT_LENGTH:
            begin
                case ($urandom_range(2))
                    0:       plen = patch ? $urandom_range(PATCH_INNER_LEN, 0) : 32'd0;
                    1:       plen = $urandom_range(32'hFFFF_FFFF, MAX_PKG - HDR_SIZE + 1);
                    default: plen ^= 32'd1 << $urandom_range(31);
                endcase
            end
            default: ;
        endcase
        for (int i = 0; i < 4; i++)
        begin
            hb[i]      = magic[i*8 +: 8];
            hb[8 + i]  = algo[i*8 +: 8];
            hb[12 + i] = key[i*8 +: 8];
            hb[32 + i] = plen[i*8 +: 8];
            hb[40 + i] = tgt[i*8 +: 8];
            hb[44 + i] = base[i*8 +: 8];
        end
        for (int i = 0; i < 2; i++)
        begin
            hb[4 + i]  = hlen[i*8 +: 8];
            hb[6 + i]  = flg[i*8 +: 8];
            hb[48 + i] = hw[i*8 +: 8];
        end
        hb[50] = lay;
        hb[51] = minb;
        for (int i = 0; i < 8; i++)
            hb[52 + i] = dig[i*8 +: 8];
        crc = '1;
        for (int i = 0; i < 60; i++)
            crc = crc_step(crc, hb[i]);
        crc = ~crc;
        if (fault == STAT_HDR_CRC)
            crc ^= 32'd1 << $urandom_range(31);
        for (int i = 0; i < 4; i++)
            hb[60 + i] = crc[i*8 +: 8];
        for (int i = 0; i < keep; i++)
            push_byte(hb[i], i == 0);
    endtask

    // Mostly well-formed headers; the rest cut-short headers, trailing idle
    // bytes and raw noise with stray starts.
    task automatic queue_random_unit();
        int         pick, n;
        logic [3:0] fault;
        pick  = $urandom_range(99);
        fault = ($urandom_range(9) < 4) ? STAT_OK
                                        : 4'($urandom_range(STAT_LENGTH, STAT_MAGIC));
        if (pick < 70)
            queue_header(fault, 64);
        else if (pick < 80)
            queue_header(fault, $urandom_range(63, 1));
        else if (pick < 90)
        begin
            queue_header(fault, 64);
            queue_idle($urandom_range(8, 1));
        end
        else
        begin
            n = $urandom_range(90, 8);
            push_byte(8'($urandom), 1'b1);
            for (int i = 1; i < n; i++)
                push_byte(8'($urandom), $urandom_range(15) == 0);
        end
    endtask

    // Let the sender run dry, collect every verdict, then give trailing idle
    // bytes time to pass before anything touches the registers.
    task automatic wait_idle();
        int guard;
        while (byte_q.size() != 0 || hdr_valid)
            @(posedge clk);
        guard = 0;
        while (verdict_q.size() != 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        if (verdict_q.size() != 0)
        begin
            flag_mismatch("verdicts never delivered, count", verdict_q.size(), 0);
            verdict_q.delete();
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    initial
    begin
        cfg_t c;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: stray bytes before any start are ignored, then one
        // header with both flag words zero (collision, counts as full)
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        queue_header(STAT_OK, 64);
        wait_idle();

        // directed: one header per verdict, a restart mid-header, idle tail;
        // the receiver goes away meanwhile so the block backs up
        load_config(random_config());
        hold_req = 1'b1;
        for (int f = STAT_OK; f <= STAT_LENGTH; f++)
            queue_header(4'(f), 64);
        queue_header(STAT_OK, 30);
        queue_header(STAT_OK, 64);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b0);
        queue_header(STAT_HDR_CRC, 64);
        wait_idle();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            c = random_config();
            case (ph)
                1:
                begin
                    // top of the hardware, layout, loader, digest and full-flag ranges; largest package
                    c.hardware_revision = '1;
                    c.layout_code       = '1;
                    c.loader_version    = '1;
                    c.current_version   = 32'hFFFF_FFFE;
                    c.base_image_digest = '1;
                    c.full_flags_value  = '1;
                    c.patch_flags_value = '0;
                    c.image_total_len   = MAX_PKG;
                end
                2:
                begin
                    // bottom of every range but the patch flags; full payload of one byte just passes
                    c.hardware_revision = '0;
                    c.layout_code       = '0;
                    c.loader_version    = '0;
                    c.current_version   = '0;
                    c.base_image_digest = '0;
                    c.full_flags_value  = '0;
                    c.patch_flags_value = '1;
                    c.image_total_len   = HDR_SIZE + 1;
                end
                3: c.patch_flags_value = c.full_flags_value;   // flag collision
                4:
                begin
                    c.current_version = '1;   // no target can be newer
                    c.image_total_len = '1;
                end
                default: ;
            endcase
            load_config(c);
            tx_pct = (ph % 4 == 1) ? 56 : (ph % 4 == 3) ? 11 : 0;
            rx_pct = (ph % 4 == 2) ? 56 : (ph % 4 == 3) ? 11 : 0;
            for (int u = 0; u < UNITS; u++)
                queue_random_unit();
            queue_header(STAT_OK, 64);   // never leave a partial header behind
            wait_idle();
        end

        if (mismatch_count == 0)
            $display("update_header_validator_core_tb passed");
        else
            $display("update_header_validator_core_tb failed");
        $finish;
    end

    initial
    begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("update_header_validator_core_tb failed");
        $finish;
    end

endmodule

FILE: files.f
sv/uhv_pkg.sv
sv/uhv_capture.sv
sv/uhv_verdict.sv
sv/update_header_validator_core.sv
tb/update_header_validator_core_tb.sv
